// File: design/hcrr_pkg.sv
// Shared types and constants for the HID control request responder.
// No dependencies; imported by every module of the block.
package hcrr_pkg;

  typedef enum logic [1:0] {
    OP_SETUP    = 2'd0,
    OP_SEND_RPT = 2'd1,
    OP_TX_DONE  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_ACCEPT   = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_STALL    = 2'd2,
    ACT_TRANSMIT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    SRC_PROTOCOL = 3'd0,
    SRC_IDLE     = 3'd1,
    SRC_ALT      = 3'd2,
    SRC_STATUS   = 3'd3,
    SRC_REPDESC0 = 3'd4,
    SRC_REPDESC1 = 3'd5,
    SRC_KBDHID   = 3'd6,
    SRC_MOUSEHID = 3'd7
  } source_e;

  localparam logic [1:0] KIND_STANDARD = 2'd0;
  localparam logic [1:0] KIND_CLASS    = 2'd1;

  localparam logic [7:0] CLS_SET_PROTOCOL = 8'h0B;
  localparam logic [7:0] CLS_GET_PROTOCOL = 8'h03;
  localparam logic [7:0] CLS_SET_IDLE     = 8'h0A;
  localparam logic [7:0] CLS_GET_IDLE     = 8'h02;

  localparam logic [7:0] STD_GET_STATUS     = 8'h00;
  localparam logic [7:0] STD_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] STD_GET_INTERFACE  = 8'h0A;
  localparam logic [7:0] STD_SET_INTERFACE  = 8'h0B;

  localparam logic [7:0] DESC_TYPE_HID    = 8'h21;
  localparam logic [7:0] DESC_TYPE_REPORT = 8'h22;
  localparam logic [15:0] HID_DESC_BYTES  = 16'd9;
  localparam logic [15:0] SHORT_RPT_LIMIT = 16'd8;

  localparam logic [7:0] EP_KEYBOARD = 8'h81;
  localparam logic [7:0] EP_MOUSE    = 8'h82;
  localparam logic [7:0] EP_NONE     = 8'h00;

  localparam logic [15:0] REPDESC0_RESET = 16'd63;
  localparam logic [15:0] REPDESC1_RESET = 16'd50;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_REPDESC0 = 1'b0;
  localparam logic REG_REPDESC1 = 1'b1;

  typedef struct packed {
    op_e         op;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] req_value;
    logic [15:0] req_index;
    logic [15:0] req_length;
    logic        configured;
  } item_t;

  typedef struct packed {
    action_e     action;
    source_e     source;
    logic [15:0] send_length;
    logic [7:0]  read_byte;
    logic [7:0]  endpoint;
  } result_t;

  typedef struct packed {
    logic [7:0] protocol_mode;
    logic [7:0] idle_rate;
    logic [7:0] alt_setting;
    logic       busy;
  } state_t;

  typedef struct packed {
    logic       set_protocol;
    logic       set_idle;
    logic       set_alt;
    logic       set_busy;
    logic       clr_busy;
    logic [7:0] value;
  } update_t;

  typedef struct packed {
    logic [15:0] repdesc0_len;
    logic [15:0] repdesc1_len;
  } cfg_t;

endpackage

// File: design/hcrr_cfg.sv
// APB-style configuration registers: report descriptor lengths.
// Depends on hcrr_pkg.
module hcrr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hcrr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output hcrr_pkg::cfg_t               cfg_o
);
  import hcrr_pkg::*;

  logic [15:0] repdesc0_q, repdesc0_d;
  logic [15:0] repdesc1_q, repdesc1_d;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    repdesc0_d = repdesc0_q;
    repdesc1_d = repdesc1_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_REPDESC0: repdesc0_d = pwdata[15:0];
        REG_REPDESC1: repdesc1_d = pwdata[15:0];
        default:      repdesc0_d = repdesc0_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repdesc0_q <= REPDESC0_RESET;
      repdesc1_q <= REPDESC1_RESET;
    end else begin
      repdesc0_q <= repdesc0_d;
      repdesc1_q <= repdesc1_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REPDESC0: prdata = {16'd0, repdesc0_q};
      REG_REPDESC1: prdata = {16'd0, repdesc1_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o.repdesc0_len = repdesc0_q;
  assign cfg_o.repdesc1_len = repdesc1_q;

endmodule

// File: design/hcrr_state.sv
// Protocol, idle rate, alternate setting and transmit busy flag.
// Depends on hcrr_pkg; updates come from hcrr_decode.
module hcrr_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  hcrr_pkg::update_t upd_i,
  output hcrr_pkg::state_t  state_o
);
  import hcrr_pkg::*;

  state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (en_i) begin
      if (upd_i.set_protocol) state_d.protocol_mode = upd_i.value;
      if (upd_i.set_idle)     state_d.idle_rate     = upd_i.value;
      if (upd_i.set_alt)      state_d.alt_setting   = upd_i.value;
      if (upd_i.set_busy)     state_d.busy          = 1'b1;
      if (upd_i.clr_busy)     state_d.busy          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: design/hcrr_decode.sv
// Combinational request decode: item and current state to result and update.
// Depends on hcrr_pkg.
module hcrr_decode (
  input  hcrr_pkg::item_t   item_i,
  input  hcrr_pkg::state_t  state_i,
  input  hcrr_pkg::cfg_t    cfg_i,
  output hcrr_pkg::result_t res_o,
  output hcrr_pkg::update_t upd_o
);
  import hcrr_pkg::*;

  logic [1:0]  kind;
  logic [7:0]  dtype;
  logic        idx_zero;
  logic [15:0] rep_len;
  logic [15:0] rep_clip;
  logic [15:0] hid_clip;

  assign kind     = item_i.request_type[6:5];
  assign dtype    = item_i.req_value[15:8];
  assign idx_zero = (item_i.req_index == 16'd0);
  assign rep_len  = idx_zero ? cfg_i.repdesc0_len : cfg_i.repdesc1_len;
  assign rep_clip = (rep_len < item_i.req_length) ? rep_len : item_i.req_length;
  assign hid_clip = (HID_DESC_BYTES < item_i.req_length) ? HID_DESC_BYTES
                                                         : item_i.req_length;

  always_comb begin
    res_o = '0;
    upd_o = '0;
    unique case (item_i.op)
      OP_SETUP: begin
        res_o.action = ACT_STALL;
        if (kind == KIND_CLASS) begin
          if (item_i.request_code == CLS_SET_PROTOCOL) begin
            upd_o.set_protocol = 1'b1;
            upd_o.value        = item_i.req_value[7:0];
            res_o.action       = ACT_ACCEPT;
          end else if (item_i.request_code == CLS_GET_PROTOCOL) begin
            res_o.action      = ACT_SEND;
            res_o.source      = SRC_PROTOCOL;
            res_o.send_length = 16'd1;
            res_o.read_byte   = state_i.protocol_mode;
          end else if (item_i.request_code == CLS_SET_IDLE) begin
            upd_o.set_idle = 1'b1;
            upd_o.value    = item_i.req_value[15:8];
            res_o.action   = ACT_ACCEPT;
          end else if (item_i.request_code == CLS_GET_IDLE) begin
            res_o.action      = ACT_SEND;
            res_o.source      = SRC_IDLE;
            res_o.send_length = 16'd1;
            res_o.read_byte   = state_i.idle_rate;
          end
        end else if (kind == KIND_STANDARD) begin
          if (item_i.request_code == STD_GET_STATUS) begin
            if (item_i.configured) begin
              res_o.action      = ACT_SEND;
              res_o.source      = SRC_STATUS;
              res_o.send_length = 16'd2;
            end
          end else if (item_i.request_code == STD_GET_DESCRIPTOR) begin
            if (dtype == DESC_TYPE_REPORT) begin
              res_o.action      = ACT_SEND;
              res_o.source      = idx_zero ? SRC_REPDESC0 : SRC_REPDESC1;
              res_o.send_length = rep_clip;
            end else if (dtype == DESC_TYPE_HID) begin
              res_o.action      = ACT_SEND;
              res_o.source      = idx_zero ? SRC_KBDHID : SRC_MOUSEHID;
              res_o.send_length = hid_clip;
            end
          end else if (item_i.request_code == STD_GET_INTERFACE) begin
            if (item_i.configured) begin
              res_o.action      = ACT_SEND;
              res_o.source      = SRC_ALT;
              res_o.send_length = 16'd1;
              res_o.read_byte   = state_i.alt_setting;
            end
          end else if (item_i.request_code == STD_SET_INTERFACE) begin
            if (item_i.configured) begin
              upd_o.set_alt = 1'b1;
              upd_o.value   = item_i.req_value[7:0];
              res_o.action  = ACT_ACCEPT;
            end
          end
        end
      end
      OP_SEND_RPT: begin
        if (item_i.configured && !state_i.busy) begin
          upd_o.set_busy    = 1'b1;
          res_o.action      = ACT_TRANSMIT;
          res_o.send_length = item_i.req_length;
          res_o.endpoint    = (item_i.req_length < SHORT_RPT_LIMIT) ? EP_MOUSE
                                                                    : EP_KEYBOARD;
        end
      end
      OP_TX_DONE: begin
        upd_o.clr_busy = 1'b1;
      end
      OP_UNUSED: begin
        res_o.action = ACT_ACCEPT;
      end
      default: begin
        res_o.action = ACT_ACCEPT;
      end
    endcase
  end

endmodule

// File: design/hid_control_request_responder.sv
// Top level of the HID control request responder: input register, decode,
// result register, state and configuration. Depends on hcrr_pkg, hcrr_cfg,
// hcrr_state and hcrr_decode.
//
// Takes one item per clock while the output is not stalled, and gives one
// result item per item. An accepted item is held in the input register,
// decoded against the current protocol/idle/alternate/busy state and
// registered into the result register when the pipeline advances, which
// waits while the result register is full and the output is stalled. The
// only loop is the state read-modify-write in the decode stage, written back
// at the same edge as the result, so back-to-back items see each other's
// updates. Configuration writes take effect at the APB access edge and should
// be made while no item is in flight.
module hid_control_request_responder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [7:0]                   request_type_i,
  input  logic [7:0]                   request_code_i,
  input  logic [15:0]                  req_value_i,
  input  logic [15:0]                  req_index_i,
  input  logic [15:0]                  req_length_i,
  input  logic                         configured_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   action_o,
  output logic [2:0]                   source_o,
  output logic [15:0]                  send_length_o,
  output logic [7:0]                   read_byte_o,
  output logic [7:0]                   endpoint_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hcrr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hcrr_pkg::*;

  item_t   item_q, item_d;
  logic    in_vld_q, in_vld_d;
  result_t res_q, res_d;
  logic    out_vld_q, out_vld_d;
  logic    advance;
  logic    in_fire;
  cfg_t    cfg;
  state_t  state;
  update_t upd;
  result_t dec_res;

  hcrr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hcrr_decode u_decode (
    .item_i  (item_q),
    .state_i (state),
    .cfg_i   (cfg),
    .res_o   (dec_res),
    .upd_o   (upd)
  );

  hcrr_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .upd_i   (upd),
    .state_o (state)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    item_d = item_q;
    in_vld_d = in_vld_q;
    if (in_fire) begin
      item_d.op           = op_e'(op_i);
      item_d.request_type = request_type_i;
      item_d.request_code = request_code_i;
      item_d.req_value    = req_value_i;
      item_d.req_index    = req_index_i;
      item_d.req_length   = req_length_i;
      item_d.configured   = configured_i;
      in_vld_d            = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    res_d     = res_q;
    out_vld_d = out_vld_q;
    if (advance) begin
      res_d     = dec_res;
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o   = out_vld_q;
  assign action_o      = res_q.action;
  assign source_o      = res_q.source;
  assign send_length_o = res_q.send_length;
  assign read_byte_o   = res_q.read_byte;
  assign endpoint_o    = res_q.endpoint;

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled while pipeline can move");

  a_tx_endpoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.action == ACT_TRANSMIT) |->
      (res_q.endpoint == EP_KEYBOARD || res_q.endpoint == EP_MOUSE))
    else $error("transmit without report endpoint");

  a_no_tx_endpoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.action != ACT_TRANSMIT) |-> res_q.endpoint == EP_NONE)
    else $error("endpoint set on non-transmit result");

  a_busy_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec_res.action == ACT_TRANSMIT) |=> state.busy)
    else $error("busy not set after transmit start");

  a_no_tx_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state.busy) |-> dec_res.action != ACT_TRANSMIT)
    else $error("transmit started while busy");

endmodule
